### sv/gf256_arith_unit_macros.svh
// assertion macros for the gf256 arithmetic unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GF256_ARITH_UNIT_MACROS_SVH
`define GF256_ARITH_UNIT_MACROS_SVH

// same-cycle implication
`define GFAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gfau_pkg.sv
// shared types, constants and helpers of the gf256 arithmetic unit
// no dependencies
package gfau_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned PolyW = DataW + 1;
  localparam int unsigned DegW  = 4;

  localparam logic [DataW-1:0] PolyReset = 8'h1B;
  localparam logic [DataW-1:0] FieldOne  = 8'h01;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_POW = 2'd2,
    CMD_INV = 2'd3
  } gfau_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV,
    ST_INV_GO,
    ST_INV_WAIT,
    ST_DONE
  } gfau_state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
  } gfau_mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] prod;
  } gfau_mul_rsp_t;

  // degree of a polynomial of up to nine bits, zero for zero
  function automatic logic [DegW-1:0] deg9(input logic [PolyW-1:0] v);
    logic [DegW-1:0] d;
    d = '0;
    for (int k = 0; k < PolyW; k++) begin
      if (v[k]) begin
        d = DegW'(k);
      end
    end
    return d;
  endfunction

endpackage

### sv/gfau_mul.sv
// bit-serial field multiplier, one bit of y per cycle with reduction
// depends on gfau_pkg
module gfau_mul
  import gfau_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DataW-1:0] poly_i,
  input  gfau_mul_req_t    req_i,
  output gfau_mul_rsp_t    rsp_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             last;

  assign last = (cnt_q == CntW'(DataW - 1));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = req_i.x;
      y_d    = req_i.y;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q[0]) begin
        acc_d = acc_q ^ x_q;
      end
      // multiply x by the field element x (0x02), reducing on overflow of the top bit
      if (x_q[DataW-1]) begin
        x_d = {x_q[DataW-2:0], 1'b0} ^ poly_i;
      end else begin
        x_d = {x_q[DataW-2:0], 1'b0};
      end
      y_d   = {1'b0, y_q[DataW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

### sv/gf256_arith_unit.sv
// add loads its result directly; multiply runs one product, power one product per unit of exponent
// inverse: per euclid round, one division step per quotient term, then one product of quotient and cofactor
// one item at a time; the next is taken the cycle after the result loads
// the bit-serial multiplier sets the pace
// async active-low reset: idle, output empty, poly_low back to 0x1b
// depends on gfau_pkg, gfau_mul and gf256_arith_unit_macros.svh
`include "gf256_arith_unit_macros.svh"

module gf256_arith_unit
  import gfau_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DataW-1:0] cfg_poly_low_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] result_o
);

  gfau_state_e      state_q, state_d;
  logic [DataW-1:0] poly_q;
  logic [DataW-1:0] z_q, z_d, base_q, base_d, cnt_q, cnt_d;
  logic [PolyW-1:0] num_q, num_d;
  logic [DataW-1:0] r1_q, r1_d, quo_q, quo_d, u0_q, u0_d, u1_q, u1_d;
  logic [DataW-1:0] res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  gfau_mul_req_t    mul_req;
  gfau_mul_rsp_t    mul_rsp;
  gfau_cmd_e        cmd;
  logic             in_fire, out_free, step_ok, mul_wait;
  logic [DegW-1:0]  num_deg, den_deg, shamt;
  logic [DataW-1:0] u2;

  assign cmd      = gfau_cmd_e'(command_i);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // one long-division step: cancel the leading term of the remainder
  assign num_deg = deg9(num_q);
  assign den_deg = deg9({1'b0, r1_q});
  assign step_ok = (num_q != '0) && (num_deg >= den_deg);
  assign shamt   = num_deg - den_deg;
  assign u2      = mul_rsp.prod ^ u0_q;

  gfau_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .poly_i (poly_q),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_ADD: state_d = ST_DONE;
            CMD_MUL: state_d = ST_MUL_GO;
            CMD_POW: state_d = (operand_b_i == '0) ? ST_DONE : ST_MUL_GO;
            CMD_INV: state_d = (operand_a_i <= FieldOne) ? ST_DONE : ST_DIV;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL_GO: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          state_d = (cnt_q == FieldOne) ? ST_DONE : ST_MUL_GO;
        end
      end
      ST_DIV: begin
        if (!step_ok) begin
          state_d = ST_INV_GO;
        end
      end
      ST_INV_GO: state_d = ST_INV_WAIT;
      ST_INV_WAIT: begin
        if (mul_rsp.done) begin
          state_d = (num_q <= PolyW'(FieldOne)) ? ST_DONE : ST_DIV;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_o    = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = z_q;
    mul_req.y     = base_q;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_MUL_GO: mul_req.start = 1'b1;
      ST_INV_GO: begin
        mul_req.start = 1'b1;
        mul_req.x     = quo_q;
        mul_req.y     = u1_q;
      end
      default: begin
        in_ready_o    = 1'b0;
        mul_req.start = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    z_d    = z_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    r1_d   = r1_q;
    quo_d  = quo_q;
    u0_d   = u0_q;
    u1_d   = u1_q;
    res_d  = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_ADD: res_d = operand_a_i ^ operand_b_i;
            CMD_MUL: begin
              z_d    = operand_a_i;
              base_d = operand_b_i;
              cnt_d  = FieldOne;
            end
            CMD_POW: begin
              z_d    = FieldOne;
              base_d = operand_a_i;
              cnt_d  = operand_b_i;
              res_d  = FieldOne;
            end
            CMD_INV: begin
              // inputs zero and one are their own results
              num_d = {1'b1, poly_q};
              r1_d  = operand_a_i;
              quo_d = '0;
              u0_d  = '0;
              u1_d  = FieldOne;
              res_d = operand_a_i;
            end
            default: res_d = res_q;
          endcase
        end
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          z_d   = mul_rsp.prod;
          cnt_d = cnt_q - 1'b1;
          res_d = mul_rsp.prod;
        end
      end
      ST_DIV: begin
        if (step_ok) begin
          num_d = num_q ^ ({1'b0, r1_q} << shamt);
          quo_d = quo_q | (FieldOne << shamt[2:0]);
        end
      end
      ST_INV_WAIT: begin
        if (mul_rsp.done) begin
          u0_d  = u1_q;
          u1_d  = u2;
          r1_d  = num_q[DataW-1:0];
          num_d = {1'b0, r1_q};
          quo_d = '0;
          res_d = u2;
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      poly_q      <= PolyReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        poly_q <= cfg_poly_low_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    num_q  <= num_d;
    r1_q   <= r1_d;
    quo_q  <= quo_d;
    u0_q   <= u0_d;
    u1_q   <= u1_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  assign mul_wait = (state_q == ST_MUL_WAIT) || (state_q == ST_INV_WAIT);

  `GFAU_ASSERT_IMP(a_start_idle, mul_req.start, !mul_rsp.busy, "multiplier restarted while busy")
  `GFAU_ASSERT_NXT(a_start_busy, mul_req.start, mul_rsp.busy, "multiplier did not take start")
  `GFAU_ASSERT_IMP(a_div_deg, state_q == ST_DIV, r1_q > FieldOne, "division by constant")
  `GFAU_ASSERT_IMP(a_done_wait, mul_rsp.done, mul_wait, "product with nobody waiting")
  `GFAU_ASSERT_IMP(a_pow_cnt, state_q == ST_MUL_WAIT, cnt_q != '0, "power count ran out")

endmodule

### tb/sv/gf256_arith_unit_checker.sv
// result checker for the gf256 arithmetic unit testbench
// watches the config, input and output transfers, predicts each result and compares
// depends on gfau_pkg
`timescale 1ns / 1ps

module gf256_arith_unit_checker
  import gfau_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [DataW-1:0] cfg_poly_low_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       command_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [DataW-1:0] result_i,
  output int               pending_o,
  output int               checked_o,
  output int               fail_count_o
);

  typedef struct {
    gfau_cmd_e        cmd;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] poly;
    logic [DataW-1:0] value;
  } field_result_t;

  field_result_t    pending_results[$];
  logic [DataW-1:0] poly_low;

  initial begin
    pending_o    = 0;
    checked_o    = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] poly);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc ^= x;
      end
      // shift out of x^7 folds back through the low byte of the polynomial
      x = x[7] ? ((x << 1) ^ poly) : (x << 1);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_power(input logic [7:0] base, input logic [7:0] expo,
                                          input logic [7:0] poly);
    logic [7:0] acc;
    acc = 8'h01;
    for (int k = 0; k < expo; k++) begin
      acc = gf_product(acc, base, poly);
    end
    return acc;
  endfunction

  function automatic int poly_degree(input logic [8:0] v);
    int d;
    d = 0;
    for (int k = 0; k < 9; k++) begin
      if (v[k]) begin
        d = k;
      end
    end
    return d;
  endfunction

  // extended euclid on remainders; stops once the remainder drops to 0 or 1
  function automatic logic [7:0] euclid_invert(input logic [7:0] a, input logic [7:0] poly);
    logic [8:0] num, den, rem;
    logic [7:0] quo, u_prev, u_cur, u_next;
    int         shift;
    if (a == '0) begin
      return '0;
    end
    num    = {1'b1, poly};
    den    = {1'b0, a};
    u_prev = '0;
    u_cur  = 8'h01;
    while (den > 9'd1) begin
      rem = num;
      quo = '0;
      while (rem != '0 && poly_degree(rem) >= poly_degree(den)) begin
        shift      = poly_degree(rem) - poly_degree(den);
        quo[shift] = 1'b1;
        rem        = rem ^ (den << shift);
      end
      u_next = gf_product(quo, u_cur, poly) ^ u_prev;
      num    = den;
      den    = rem;
      u_prev = u_cur;
      u_cur  = u_next;
    end
    return u_cur;
  endfunction

  function automatic logic [7:0] field_result(input gfau_cmd_e cmd, input logic [7:0] a,
                                              input logic [7:0] b, input logic [7:0] poly);
    case (cmd)
      CMD_ADD: return a ^ b;
      CMD_MUL: return gf_product(a, b, poly);
      CMD_POW: return gf_power(a, b, poly);
      default: return euclid_invert(a, poly);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    field_result_t item;
    if (!rst_ni) begin
      poly_low = PolyReset;
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        poly_low = cfg_poly_low_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %02h with no transfer outstanding", result_i));
        end else begin
          item = pending_results.pop_front();
          checked_o++;
          if (result_i !== item.value) begin
            report_mismatch($sformatf("%s a=%02h b=%02h poly=%02h: got %02h, want %02h",
                                      item.cmd.name(), item.a, item.b, item.poly,
                                      result_i, item.value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        item.cmd   = gfau_cmd_e'(command_i);
        item.a     = operand_a_i;
        item.b     = operand_b_i;
        item.poly  = poly_low;
        item.value = field_result(item.cmd, operand_a_i, operand_b_i, poly_low);
        pending_results.push_back(item);
      end
    end
    // nonblocking so the stimulus side sees a settled count at each edge
    pending_o <= pending_results.size();
  end

endmodule

### tb/sv/gf256_arith_unit_tb.sv
// top of the gf256 arithmetic unit testbench: clock, reset, stimulus and verdict
// depends on gfau_pkg, gf256_arith_unit and gf256_arith_unit_checker
`timescale 1ns / 1ps

module gf256_arith_unit_tb
  import gfau_pkg::*;
();

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 88;
  localparam int unsigned NumPhases   = 6;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [DataW-1:0] cfg_poly_low = '0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [1:0]       command      = '0;
  logic [DataW-1:0] operand_a    = '0;
  logic [DataW-1:0] operand_b    = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [DataW-1:0] result;

  int pending;
  int checked;
  int fail_count;
  int items_sent = 0;
  bit hold_req   = 1'b0;
  bit calm       = 1'b0;

  always #10 clk = ~clk;

  gf256_arith_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_poly_low_i (cfg_poly_low),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_o       (result)
  );

  gf256_arith_unit_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_poly_low_i (cfg_poly_low),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (command),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_i       (result),
    .pending_o      (pending),
    .checked_o      (checked),
    .fail_count_o   (fail_count)
  );

  function automatic int unsigned gap_cycles();
    int unsigned roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners [4];
    corners = '{8'h00, 8'h01, 8'h80, 8'hFF};
    if ($urandom_range(0, 9) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a clock edge; returns at the edge of the transfer or after the gap
  task automatic send_item(input gfau_cmd_e cmd, input logic [7:0] a, input logic [7:0] b);
    int unsigned gap;
    in_valid  <= 1'b1;
    command   <= cmd;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    gfau_cmd_e  cmd;
    logic [7:0] a;
    logic [7:0] b;
    cmd = gfau_cmd_e'($urandom_range(0, 3));
    a   = pick_operand();
    // keep most exponents small, the unit runs one product per unit of exponent
    if (cmd == CMD_POW && $urandom_range(0, 9) < 7) begin
      b = 8'($urandom_range(0, 15));
    end else begin
      b = pick_operand();
    end
    send_item(cmd, a, b);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_poly(input logic [7:0] value);
    wait_results_drained();
    cfg_valid    <= 1'b1;
    cfg_poly_low <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin : result_side
    int unsigned roll;
    int unsigned stretch;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          stretch = $urandom_range(1, 3);
        end else if (roll < 95) begin
          stretch = $urandom_range(4, 10);
        end else begin
          stretch = $urandom_range(20, 60);
        end
        repeat (stretch) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] poly_plan [NumPhases];
    poly_plan = '{8'h1D, 8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h8D, 8'h1B};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset polynomial
    send_item(CMD_ADD, 8'h00, 8'h00);
    send_item(CMD_ADD, 8'hFF, 8'hFF);
    send_item(CMD_ADD, 8'hA5, 8'h5A);
    send_item(CMD_MUL, 8'hFF, 8'hFF);
    send_item(CMD_MUL, 8'h53, 8'hCA);
    send_item(CMD_MUL, 8'h00, 8'hFF);
    send_item(CMD_MUL, 8'h80, 8'h02);
    send_item(CMD_POW, 8'h00, 8'h00);
    send_item(CMD_POW, 8'h03, 8'h00);
    send_item(CMD_POW, 8'h03, 8'hFF);
    send_item(CMD_POW, 8'hFF, 8'h01);
    send_item(CMD_POW, 8'h00, 8'h05);
    send_item(CMD_INV, 8'h00, 8'hFF);
    send_item(CMD_INV, 8'h01, 8'h00);
    send_item(CMD_INV, 8'hFF, 8'hAA);
    send_item(CMD_INV, 8'h53, 8'h00);
    send_item(CMD_INV, 8'h80, 8'h55);

    for (int p = 0; p < NumPhases; p++) begin
      write_poly(poly_plan[p]);
      calm = (p == 2);
      // long output stall while the input keeps offering, so the input backs up
      if (p == 1) begin
        hold_req = 1'b1;
      end
      if (poly_plan[p] == 8'h00 || poly_plan[p] == 8'hFF) begin
        send_item(CMD_INV, 8'h02, 8'h00);
        send_item(CMD_INV, 8'h80, 8'hFF);
        send_item(CMD_MUL, 8'h80, 8'h80);
      end
      repeat (PhaseItems) send_random_item();
      calm = 1'b0;
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("%0d items over %0d polynomial settings, %0d results checked",
             items_sent, NumPhases + 1, checked);
    $display("covered all four commands, zero exponent, zero inverse, x^8 and reducible polys");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #150_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
